FILE: rtl/clipped_span_pixel_writer_assert.svh
// Assertion macros shared by the span writer RTL.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef CLIPPED_SPAN_PIXEL_WRITER_ASSERT_SVH
`define CLIPPED_SPAN_PIXEL_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define CSPW_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("span writer assertion failed");
// ante implies cons in the cycle after
`define CSPW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("span writer assertion failed");
`else
`define CSPW_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CSPW_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/cspw_pkg.sv
// Shared constants, types and pixel conversion functions for the span writer.
// No dependencies.
`default_nettype none

package cspw_pkg;

  localparam int MAX_SPAN_DEF = 32;
  localparam int MAX_RES_DEF  = 2048;

  localparam int COORD_W  = 12;
  localparam int WIDTH_W  = 6;
  localparam int MASK_W   = 32;
  localparam int DATA_W   = 32;
  localparam int RES_W    = 12;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_RES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_RES      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIX_FMT    = 2'd3;

  // pixel formats
  localparam logic [1:0] FMT_8BPP  = 2'd0;
  localparam logic [1:0] FMT_16BPP = 2'd1;
  localparam logic [1:0] FMT_32BPP = 2'd2;
  localparam logic [1:0] FMT_BAD   = 2'd3;

  // write sizes; the code doubles as log2 of bytes per pixel
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [COORD_W-1:0] RES_X_RST = 12'd1024;
  localparam logic [COORD_W-1:0] RES_Y_RST = 12'd768;

  typedef struct packed {
    logic fire;   // emit the lowest pending pixel
    logic err;    // emit the format error item
  } emit_ctrl_t;

  function automatic logic [15:0] to_rgb565(input logic [DATA_W-1:0] c);
    to_rgb565 = {c[23:19], c[15:10], c[7:3]};
  endfunction

  function automatic logic [1:0] pixel_size(input logic [1:0] fmt);
    case (fmt)
      FMT_8BPP:  pixel_size = SIZE_BYTE;
      FMT_16BPP: pixel_size = SIZE_HALF;
      default:   pixel_size = SIZE_WORD;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pixel_data(input logic [1:0] fmt,
                                                   input logic [DATA_W-1:0] c);
    case (fmt)
      FMT_8BPP:  pixel_data = {24'd0, c[7:0]};
      FMT_16BPP: pixel_data = {16'd0, to_rgb565(c)};
      default:   pixel_data = c;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cspw_lane.sv
// One pixel lane: decides whether pixel LANE of the span is drawn.
// Depends on cspw_pkg.
`default_nettype none

module cspw_lane #(
  parameter int LANE = 0,
  parameter int CW   = 12
) (
  input  wire logic [cspw_pkg::COORD_W-1:0] span_x,
  input  wire logic [cspw_pkg::WIDTH_W-1:0] span_width,
  input  wire logic                         opcode,
  input  wire logic                         mask_bit,
  input  wire logic [CW-1:0]                xres,
  output logic                              drawn
);

  localparam logic [cspw_pkg::COORD_W:0]   OFF  = (cspw_pkg::COORD_W+1)'(LANE);
  localparam logic [cspw_pkg::WIDTH_W:0]   LIDX = (cspw_pkg::WIDTH_W+1)'(LANE);

  logic [cspw_pkg::COORD_W:0] x;
  logic in_span;
  logic visible;

  // sign-extend then add the lane offset; bit COORD_W is the sign
  assign x       = {span_x[cspw_pkg::COORD_W-1], span_x} + OFF;
  assign in_span = LIDX < {1'b0, span_width};
  assign visible = !x[cspw_pkg::COORD_W] && (CW'(x[cspw_pkg::COORD_W-1:0]) < xres);
  assign drawn   = in_span && visible && (!opcode || mask_bit);

endmodule

`default_nettype wire

FILE: rtl/cspw_emit.sv
// Merge stage: picks the lowest pending pixel each cycle and registers the write.
// Depends on cspw_pkg and clipped_span_pixel_writer_assert.svh.
`default_nettype none
`include "clipped_span_pixel_writer_assert.svh"

module cspw_emit #(
  parameter int MAX_SPAN = cspw_pkg::MAX_SPAN_DEF,
  parameter int IW       = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cspw_pkg::emit_ctrl_t          ctrl,
  input  wire logic [MAX_SPAN-1:0]           pending,
  input  wire logic [31:0]                   row_base,
  input  wire logic [cspw_pkg::COORD_W-1:0]  span_x,
  input  wire logic [1:0]                    size,
  input  wire logic [cspw_pkg::DATA_W-1:0]   data,
  output logic      [MAX_SPAN-1:0]           pick,
  output logic                               last_pick,
  output logic                               strobe,
  output logic      [31:0]                   write_address,
  output logic      [cspw_pkg::DATA_W-1:0]   write_data,
  output logic      [1:0]                    write_size,
  output logic                               format_error,
  output logic                               last
);

  logic [IW-1:0]                idx;
  logic [cspw_pkg::COORD_W-1:0] col;
  logic [31:0]                  addr;

  assign pick      = pending & (~pending + MAX_SPAN'(1));
  assign last_pick = (pending & ~pick) == '0;

  // one-hot to index
  always_comb begin
    idx = '0;
    for (int i = 0; i < MAX_SPAN; i++) begin
      if (pick[i]) idx = idx | IW'(i);
    end
  end

  // drawn pixels are on screen, so x fits the coordinate width unsigned
  assign col  = span_x + cspw_pkg::COORD_W'(idx);
  assign addr = row_base + (32'(col) << size);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.fire || ctrl.err;
    end
    if (ctrl.err) begin
      write_address <= '0;
      write_data    <= '0;
      write_size    <= cspw_pkg::SIZE_BYTE;
      format_error  <= 1'b1;
      last          <= 1'b1;
    end else begin
      write_address <= addr;
      write_data    <= data;
      write_size    <= size;
      format_error  <= 1'b0;
      last          <= last_pick;
    end
  end

  `CSPW_ASSERT_IMP(a_fire_onehot, clk, rst, ctrl.fire, $onehot(pick))
  `CSPW_ASSERT_IMP(a_fire_excl, clk, rst, ctrl.fire, !ctrl.err)
  `CSPW_ASSERT_IMP(a_err_shape, clk, rst, strobe && format_error,
                   last && write_address == 32'd0 && write_data == '0)

endmodule

`default_nettype wire

FILE: rtl/clipped_span_pixel_writer.sv
// Top level of the clipped span pixel writer: config registers, lanes, sequencer.
// Depends on cspw_pkg, cspw_lane, cspw_emit, clipped_span_pixel_writer_assert.svh.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  item in  | start, busy               | opcode span_x row_y span_width pixel_mask color
//  config   | cfg_write                 | cfg_index cfg_data
//  result   | strobe (one cycle, no hold)| write_address write_data write_size
//           |                           |   format_error last
//
// An item is taken when start is high and busy is low. It then goes through CALC,
// where all lanes test their pixel in parallel and the row product y*x_resolution
// is formed, ROW, where the frame base is added, then EMIT, one write per cycle
// out of the merge stage's priority pick, one per drawn pixel. Each result
// appears in the cycle after it is picked. An invisible span goes idle from ROW
// with no result; a bad format goes idle from CALC with its single error result.
// rst (synchronous) clears the sequencer and loads the register reset values.
// The receiver cannot stall; results are never held back.
`default_nettype none
`include "clipped_span_pixel_writer_assert.svh"

module clipped_span_pixel_writer #(
  parameter int MAX_SPAN       = cspw_pkg::MAX_SPAN_DEF,
  parameter int MAX_RESOLUTION = cspw_pkg::MAX_RES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // item in
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            opcode,
  input  wire logic [cspw_pkg::COORD_W-1:0]    span_x,
  input  wire logic [cspw_pkg::COORD_W-1:0]    row_y,
  input  wire logic [cspw_pkg::WIDTH_W-1:0]    span_width,
  input  wire logic [cspw_pkg::MASK_W-1:0]     pixel_mask,
  input  wire logic [cspw_pkg::DATA_W-1:0]     color,
  // configuration
  input  wire logic                            cfg_write,
  input  wire logic [cspw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                     cfg_data,
  // results
  output logic                                 strobe,
  output logic [31:0]                          write_address,
  output logic [cspw_pkg::DATA_W-1:0]          write_data,
  output logic [1:0]                           write_size,
  output logic                                 format_error,
  output logic                                 last
);

  // clamped resolutions need room for MAX_RESOLUTION and for any 12-bit register
  localparam int RW = $clog2(MAX_RESOLUTION + 1);
  localparam int CW = (RW > cspw_pkg::RES_W) ? RW : cspw_pkg::RES_W;
  localparam int IW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam int YW = cspw_pkg::COORD_W - 1;    // magnitude bits of a visible y
  localparam int PW = YW + CW;
  localparam logic [CW-1:0] RES_MAX = CW'(MAX_RESOLUTION);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ROW,
    ST_EMIT
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0]                  frame_base;
  logic [cspw_pkg::RES_W-1:0]   x_resolution;
  logic [cspw_pkg::RES_W-1:0]   y_resolution;
  logic [1:0]                   pixel_format;

  // latched item
  logic                         opcode_r;
  logic [cspw_pkg::COORD_W-1:0] span_x_r;
  logic [cspw_pkg::COORD_W-1:0] row_y_r;
  logic [cspw_pkg::WIDTH_W-1:0] span_width_r;
  logic [cspw_pkg::MASK_W-1:0]  pixel_mask_r;
  logic [cspw_pkg::DATA_W-1:0]  color_r;

  logic [MAX_SPAN-1:0]          drawn;
  logic [MAX_SPAN-1:0]          pending;
  logic [MAX_SPAN-1:0]          pick;
  logic                         last_pick;
  logic [PW-1:0]                row_prod;
  logic [31:0]                  row_base;

  logic [CW-1:0]                xres_c;
  logic [CW-1:0]                yres_c;
  logic                         y_visible;
  logic                         accept;
  logic [1:0]                   size;
  logic [cspw_pkg::DATA_W-1:0]  data;
  cspw_pkg::emit_ctrl_t         ctrl;

  assign xres_c = (CW'(x_resolution) > RES_MAX) ? RES_MAX : CW'(x_resolution);
  assign yres_c = (CW'(y_resolution) > RES_MAX) ? RES_MAX : CW'(y_resolution);

  assign busy   = state != ST_IDLE;
  assign accept = start && !busy;

  assign y_visible = !row_y_r[cspw_pkg::COORD_W-1] && (CW'(row_y_r[YW-1:0]) < yres_c);
  assign size      = cspw_pkg::pixel_size(pixel_format);
  assign data      = cspw_pkg::pixel_data(pixel_format, color_r);

  assign ctrl.fire = state == ST_EMIT;
  assign ctrl.err  = (state == ST_CALC) && (pixel_format == cspw_pkg::FMT_BAD);

  // lanes: the first MAX_SPAN pixels of the span are tested in the same cycle
  for (genvar p = 0; p < MAX_SPAN; p++) begin : g_lane
    logic mbit;
    if (p < cspw_pkg::MASK_W) begin : g_mask
      assign mbit = pixel_mask_r[p];
    end else begin : g_nomask
      assign mbit = 1'b0;    // no mask bit past the mask width
    end
    cspw_lane #(
      .LANE (p),
      .CW   (CW)
    ) u_lane (
      .span_x     (span_x_r),
      .span_width (span_width_r),
      .opcode     (opcode_r),
      .mask_bit   (mbit),
      .xres       (xres_c),
      .drawn      (drawn[p])
    );
  end

  cspw_emit #(
    .MAX_SPAN (MAX_SPAN),
    .IW       (IW)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .pending       (pending),
    .row_base      (row_base),
    .span_x        (span_x_r),
    .size          (size),
    .data          (data),
    .pick          (pick),
    .last_pick     (last_pick),
    .strobe        (strobe),
    .write_address (write_address),
    .write_data    (write_data),
    .write_size    (write_size),
    .format_error  (format_error),
    .last          (last)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base   <= '0;
      x_resolution <= cspw_pkg::RES_X_RST;
      y_resolution <= cspw_pkg::RES_Y_RST;
      pixel_format <= cspw_pkg::FMT_16BPP;
    end else if (cfg_write) begin
      case (cfg_index)
        cspw_pkg::REG_FRAME_BASE: frame_base   <= cfg_data;
        cspw_pkg::REG_X_RES:      x_resolution <= cfg_data[cspw_pkg::RES_W-1:0];
        cspw_pkg::REG_Y_RES:      y_resolution <= cfg_data[cspw_pkg::RES_W-1:0];
        cspw_pkg::REG_PIX_FMT:    pixel_format <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) state <= ST_CALC;
        end
        ST_CALC: begin
          if (pixel_format == cspw_pkg::FMT_BAD) state <= ST_IDLE;
          else state <= ST_ROW;
        end
        ST_ROW: begin
          if (pending == '0) state <= ST_IDLE;
          else state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (last_pick) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_r     <= opcode;
      span_x_r     <= span_x;
      row_y_r      <= row_y;
      span_width_r <= span_width;
      pixel_mask_r <= pixel_mask;
      color_r      <= color;
    end
    if (state == ST_CALC) begin
      pending  <= y_visible ? drawn : '0;
      row_prod <= PW'(row_y_r[YW-1:0]) * PW'(xres_c);
    end else if (state == ST_EMIT) begin
      pending  <= pending & ~pick;
    end
    if (state == ST_ROW) begin
      row_base <= frame_base + (32'(row_prod) << size);
    end
  end

  `CSPW_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy && state == ST_CALC)
  `CSPW_ASSERT_IMP(a_emit_pending, clk, rst, state == ST_EMIT, pending != '0)
  `CSPW_ASSERT_NEXT(a_emit_strobe, clk, rst, state == ST_EMIT,
                    strobe && !format_error)

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for clipped_span_pixel_writer: directed and random spans
// through several register settings. Depends on cspw_pkg and the RTL only.
`timescale 1ns / 1ps

// One framebuffer write as seen on the result ports
typedef struct {
  bit [31:0] address;
  bit [31:0] data;
  bit [1:0]  size;
  bit        format_error;
  bit        last;
} pixel_write_t;

// Holds a copy of the registers and the queue of writes the block still owes.
class framebuffer_writes;
  localparam int SPAN_LIMIT = cspw_pkg::MAX_SPAN_DEF;
  localparam int RES_LIMIT  = cspw_pkg::MAX_RES_DEF;

  bit [31:0]    base;
  bit [11:0]    xres;
  bit [11:0]    yres;
  bit [1:0]     fmt;
  pixel_write_t due[$];
  int           errors;

  function new();
    base   = 32'd0;
    xres   = 12'd1024;
    yres   = 12'd768;
    fmt    = cspw_pkg::FMT_16BPP;
    errors = 0;
  endfunction

  function void set_reg(logic [cspw_pkg::CFG_IDX_W-1:0] idx, bit [31:0] value);
    case (idx)
      cspw_pkg::REG_FRAME_BASE: base = value;
      cspw_pkg::REG_X_RES:      xres = value[11:0];
      cspw_pkg::REG_Y_RES:      yres = value[11:0];
      cspw_pkg::REG_PIX_FMT:    fmt  = value[1:0];
      default: ;
    endcase
  endfunction

  function int columns();
    return (xres > RES_LIMIT) ? RES_LIMIT : int'(xres);
  endfunction

  function int rows();
    return (yres > RES_LIMIT) ? RES_LIMIT : int'(yres);
  endfunction

  // Works out every write one accepted span causes and queues them in x order.
  function void note_span(bit op, logic [11:0] x, logic [11:0] y, logic [5:0] w,
                          bit [31:0] mask, bit [31:0] color);
    pixel_write_t wr;
    pixel_write_t row[$];
    int           sx, sy, px, n, xr, yr, nbytes;
    bit [1:0]     size;
    bit [31:0]    value;
    bit [7:0]     r, g, b;
    sx = $signed(x);
    sy = $signed(y);
    n  = (w > SPAN_LIMIT) ? SPAN_LIMIT : int'(w);
    xr = columns();
    yr = rows();
    if (fmt == cspw_pkg::FMT_BAD) begin
      // unsupported format: one error item per span, visible or not
      wr = '{32'd0, 32'd0, 2'd0, 1'b1, 1'b1};
      due.push_back(wr);
      return;
    end
    r = color[23:16];
    g = color[15:8];
    b = color[7:0];
    case (fmt)
      cspw_pkg::FMT_8BPP: begin
        size  = cspw_pkg::SIZE_BYTE;
        value = 32'(b);
      end
      cspw_pkg::FMT_16BPP: begin
        size  = cspw_pkg::SIZE_HALF;
        value = (32'(r >> 3) << 11) | (32'(g >> 2) << 5) | 32'(b >> 3);
      end
      default: begin
        size  = cspw_pkg::SIZE_WORD;
        value = color;
      end
    endcase
    nbytes = 1 << size;
    if (sy < 0 || sy >= yr)
      return;
    for (int p = 0; p < n; p++) begin
      px = sx + p;
      if (px < 0 || px >= xr)
        continue;
      if (op && !(p < 32 && mask[p]))
        continue;
      wr.address      = base + 32'(sy) * 32'(xr * nbytes) + 32'(px) * 32'(nbytes);
      wr.data         = value;
      wr.size         = size;
      wr.format_error = 1'b0;
      wr.last         = 1'b0;
      row.push_back(wr);
    end
    if (row.size() > 0)
      row[row.size()-1].last = 1'b1;
    foreach (row[i])
      due.push_back(row[i]);
  endfunction

  function void compare(string field, bit [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errors++;
    end
  endfunction

  function void check_write(logic [31:0] address, logic [31:0] data, logic [1:0] size,
                            logic format_error, logic last);
    pixel_write_t wr;
    if (due.size() == 0) begin
      $error("write to %0h with none outstanding", address);
      errors++;
      return;
    end
    wr = due.pop_front();
    compare("write_address", wr.address, address);
    compare("write_data", wr.data, data);
    compare("write_size", 32'(wr.size), 32'(size));
    compare("format_error", 32'(wr.format_error), 32'(format_error));
    compare("last", 32'(wr.last), 32'(last));
  endfunction
endclass

module testbench;
  import cspw_pkg::*;

  localparam int  CLK_PERIOD = 20;
  localparam int  SETTLE     = 8;       // an invisible span still runs through the sequencer
  localparam bit  OP_FILL    = 1'b0;
  localparam bit  OP_GLYPH   = 1'b1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 opcode = 1'b0;
  logic [COORD_W-1:0]   span_x = '0;
  logic [COORD_W-1:0]   row_y = '0;
  logic [WIDTH_W-1:0]   span_width = '0;
  logic [MASK_W-1:0]    pixel_mask = '0;
  logic [DATA_W-1:0]    color = '0;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 strobe;
  logic [31:0]          write_address;
  logic [DATA_W-1:0]    write_data;
  logic [1:0]           write_size;
  logic                 format_error;
  logic                 last;

  framebuffer_writes writes = new();
  int                burst_left = 0;

  clipped_span_pixel_writer i_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .opcode(opcode), .span_x(span_x), .row_y(row_y), .span_width(span_width),
    .pixel_mask(pixel_mask), .color(color),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .strobe(strobe), .write_address(write_address), .write_data(write_data),
    .write_size(write_size), .format_error(format_error), .last(last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Results cannot be held off: every strobe is checked at the edge ending it.
  always @(posedge clk) begin
    if (!rst && strobe)
      writes.check_write(write_address, write_data, write_size, format_error, last);
  end

  // Stop sending, wait for every owed write and for the block to go quiet.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (writes.due.size() != 0 || busy);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Sender works in bursts; between bursts a random gap, now and then a full drain.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) begin
        drain();
      end else if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Present one span and hold it until the block takes it; start stays high after.
  task automatic send_span(bit op, logic [11:0] x, logic [11:0] y, logic [5:0] w,
                           bit [31:0] mask, bit [31:0] rgb);
    pace();
    start      <= 1'b1;
    opcode     <= op;
    span_x     <= x;
    row_y      <= y;
    span_width <= w;
    pixel_mask <= mask;
    color      <= rgb;
    @(posedge clk);
    while (busy) @(posedge clk);
    writes.note_span(op, x, y, w, mask, rgb);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    writes.set_reg(idx, value);
  endtask

  // All four registers; junk in the unused upper bits of the narrow ones.
  task automatic configure(bit [31:0] base, int xr, int yr, bit [1:0] fmt);
    write_reg(REG_FRAME_BASE, base);
    write_reg(REG_X_RES, ($urandom & 32'hFFFF_F000) | 32'(xr));
    write_reg(REG_Y_RES, ($urandom & 32'hFFFF_F000) | 32'(yr));
    write_reg(REG_PIX_FMT, ($urandom & 32'hFFFF_FFFC) | 32'(fmt));
    cfg_write <= 1'b0;
  endtask

  // Mostly near the visible area so clipping edges get hit; sometimes anywhere.
  function automatic logic [11:0] pick_coord(int lim, int margin);
    int v;
    if ($urandom_range(0, 7) == 0)
      return 12'($urandom);
    v = int'($urandom_range(lim + 2 * margin)) - margin;
    if (v > 2047)
      v = 2047;
    return 12'(v);
  endfunction

  task automatic random_spans(int count);
    int        w;
    bit [31:0] mask;
    repeat (count) begin
      case ($urandom_range(0, 15))
        0:       w = 0;
        1:       w = $urandom_range(33, 63);   // saturates to the span limit
        2:       w = 32;
        default: w = $urandom_range(1, 32);
      endcase
      case ($urandom_range(0, 9))
        0:       mask = 32'hFFFF_FFFF;
        1:       mask = 32'h0;
        default: mask = $urandom;
      endcase
      send_span($urandom_range(0, 1), pick_coord(writes.columns(), 40),
                pick_coord(writes.rows(), 3), 6'(w), mask, $urandom);
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, at the reset settings: 1024 x 768, 16 bpp, base 0
    send_span(OP_FILL, 0, 0, 32, 32'h0, 32'hFFFF_FFFF);
    send_span(OP_FILL, 0, 0, 0, 32'hFFFF_FFFF, 32'h1234_5678);    // empty span
    send_span(OP_FILL, 100, 10, 63, 32'h0, 32'h0);                // oversized width
    send_span(OP_FILL, -2048, 5, 32, 32'h0, 32'h00AB_CDEF);       // far left, invisible
    send_span(OP_FILL, 2047, 5, 8, 32'h0, 32'h00AB_CDEF);         // far right, invisible
    send_span(OP_FILL, -5, 1, 10, 32'h0, 32'h0080_4020);          // left clip
    send_span(OP_FILL, 1020, 767, 8, 32'h0, 32'h00F8_FCF8);       // right clip, last row
    send_span(OP_FILL, 0, -1, 4, 32'h0, 32'h1);
    send_span(OP_FILL, 0, 768, 4, 32'h0, 32'h2);
    send_span(OP_FILL, 0, 2047, 4, 32'h0, 32'h3);
    send_span(OP_FILL, 0, -2048, 4, 32'h0, 32'h4);
    send_span(OP_FILL, 1023, 383, 1, 32'h0, 32'h00FF_0000);       // mask ignored
    send_span(OP_GLYPH, 200, 300, 32, 32'hFFFF_FFFF, 32'h0000_FF00);
    send_span(OP_GLYPH, 200, 301, 32, 32'h0, 32'h0000_00FF);      // nothing drawn
    send_span(OP_GLYPH, 200, 302, 32, 32'h8000_0001, 32'h00FF_FFFF);
    send_span(OP_GLYPH, 500, 303, 63, 32'hFFFF_FFFF, 32'hFF07_0307);
    send_span(OP_GLYPH, -3, 767, 20, 32'hAAAA_5555, 32'h5A5A_A5A5);
    send_span(OP_GLYPH, 1010, 0, 32, 32'h0000_7FFF, 32'hFFFF_FFFF);
    send_span(OP_GLYPH, 0, 0, 1, 32'hFFFF_FFFE, 32'h0);           // bit 0 clear
    drain();

    // Register settings, extremes among them
    configure(32'h0000_1000, 640, 480, FMT_8BPP);
    random_spans(14);
    configure(32'hFFFF_FFF0, 2048, 2048, FMT_32BPP);             // addresses wrap
    random_spans(12);
    configure($urandom, 4095, 4095, FMT_16BPP);                  // both resolutions clamp
    random_spans(12);
    configure($urandom, 1, 1, FMT_8BPP);
    random_spans(10);
    configure(32'h0, 17, 9, FMT_BAD);                            // error item per span
    random_spans(10);
    configure(32'h8000_0000, 0, 0, FMT_32BPP);                   // zero resolution: no writes
    random_spans(6);
    configure($urandom, $urandom_range(1, 4095), $urandom_range(1, 4095),
              2'($urandom_range(0, 2)));
    random_spans(14);
    configure(32'hFFFF_FFFF, 2048, 1, FMT_16BPP);
    random_spans(12);

    if (writes.due.size() != 0) begin
      $error("%0d writes never arrived", writes.due.size());
      writes.errors++;
    end
    if (writes.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #(200_000 * CLK_PERIOD);
    $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cspw_pkg.sv
rtl/cspw_lane.sv
rtl/cspw_emit.sv
rtl/clipped_span_pixel_writer.sv
verif/testbench.sv
